// ----- src/sknv_pkg.sv -----
// Shared types, codes and helper functions for the 2D vertex skinning block.
// Used by blend_skin_vertex_2d, sknv_div and tb_top; no dependencies of its own.
package sknv_pkg;

	typedef struct packed {
		logic        [1:0]  command;
		logic        [5:0]  node_index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] pivot_x;
		logic signed [31:0] pivot_y;
		logic        [15:0] angle;
		logic signed [15:0] weight;
		logic               last_influence;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic        [1:0]  status;
	} res_item_t;

	// One pose slot as stored in the pose memory.
	typedef struct packed {
		logic signed [31:0] sin_v;
		logic signed [31:0] cos_v;
		logic signed [31:0] py;
		logic signed [31:0] px;
		logic signed [31:0] sy;
		logic signed [31:0] sx;
		logic signed [31:0] ty;
		logic signed [31:0] tx;
	} pose_t;

	// Divider handshake from the top level toward the divider.
	typedef struct packed {
		logic start;
		logic sel_y;
	} div_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_LOAD_WR,
		ST_MUL,
		ST_CHECK,
		ST_DIVX_GO,
		ST_DIVX_WAIT,
		ST_DIVY_GO,
		ST_DIVY_WAIT,
		ST_FINISH
	} state_t;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_INFL  = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_MISSING  = 2'd1;
	localparam logic [1:0] STAT_NEG      = 2'd2;
	localparam logic [1:0] STAT_NONPOS   = 2'd3;

	localparam int ATAN_COUNT = 24;
	localparam int MUL_LAST   = 8;
	localparam int DIV_BITS   = 64;
	localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

	// Rotation angle per step, 2^32 units per full turn.
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -68'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ----- src/sknv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module sknv_ram #(
	parameter int WIDTH = 256,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ----- src/sknv_div.sv -----
// Bit-serial signed 64 / positive 32 divider, truncating, with 32-bit saturation.
// Depends on sknv_pkg.
module sknv_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sknv_pkg::div_ctrl_t      ctrl,
	input  logic signed [63:0]       sum_x,
	input  logic signed [63:0]       sum_y,
	input  logic        [31:0]       divisor,
	output logic                     done,
	output logic signed [31:0]       quotient
);
	import sknv_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [5:0]           cnt_q;
	logic                 neg_q;
	logic [31:0]          rem_q;
	logic [DIV_BITS-1:0]  quo_q;
	logic signed [63:0]   dividend;
	logic [63:0]          mag;
	logic [32:0]          shifted;
	logic                 fits;

	assign dividend = ctrl.sel_y ? sum_y : sum_x;
	assign mag      = dividend[63] ? 64'(-dividend) : 64'(dividend);
	assign shifted  = {rem_q, quo_q[DIV_BITS-1]};
	assign fits     = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The remainder stays below the divisor, which is under 2^31.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			neg_q <= dividend[63];
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(shifted - {1'b0, divisor}) : shifted[31:0];
			quo_q <= {quo_q[DIV_BITS-2:0], fits};
		end
	end

	always_comb begin
		if (neg_q)
			quotient = (quo_q > 64'h8000_0000) ? 32'sh80000000 : 32'(-quo_q[31:0]);
		else
			quotient = (quo_q > 64'h7fff_ffff) ? 32'sh7fffffff : quo_q[31:0];
	end

	assign done = done_q;
endmodule

// ----- src/blend_skin_vertex_2d.sv -----
// Channel | role   | payload            | handshake
// cmd     | input  | cmd_item_t command | cmd_valid / cmd_stall
// res     | output | res_item_t result  | res_valid / res_stall
//
// A pose load runs the shift-add CORDIC loop for CORDIC_STEPS steps (capped at 24 steps).
// An influence runs on the one shared 33x33
// multiplier; a last influence adds bit-serial division (x then y).
// Reset clears the valid bits, accumulators and control; pose memory holds junk until loaded.
// cmd_stall is high while an item is in work; a finished result waits in the output
// register, and only the next result waits for res_stall to drop.
// Depends on sknv_pkg, sknv_ram, sknv_div.
module blend_skin_vertex_2d #(
	parameter int NODES        = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  sknv_pkg::cmd_item_t   cmd,
	output logic                  res_valid,
	input  logic                  res_stall,
	output sknv_pkg::res_item_t   res
);
	import sknv_pkg::*;

	localparam int AW      = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int C_STEPS = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;

	state_t              state_q, state_d;
	cmd_item_t           in_q;
	logic [4:0]          cnt_q;
	logic [NODES-1:0]    pose_valid_q;
	logic signed [63:0]  sum_x_q, sum_y_q;
	logic [31:0]         weight_sum_q;
	logic [1:0]          vstat_q, stat_q, stat_calc;
	logic                flip_q;
	logic signed [33:0]  cx_q, cy_q, cz_q;
	logic signed [31:0]  lx_q, ly_q, ox_q;
	logic signed [65:0]  prod_q, t_q;
	logic signed [32:0]  mul_a, mul_b;
	logic signed [65:0]  product;
	res_item_t           res_q;
	logic                res_valid_q;

	logic                accept, in_range, missing;
	logic [AW-1:0]       addr;
	logic                ram_we, ram_re;
	logic [$bits(pose_t)-1:0] ram_rdata;
	pose_t               pose, pose_wr;
	div_ctrl_t           div_ctrl;
	logic                div_done;
	logic signed [31:0]  div_q;
	logic [15:0]         ang_fix;
	logic signed [33:0]  xs, ys;
	logic                res_free;

	assign accept   = cmd_valid && !cmd_stall;
	assign in_range = {5'd0, cmd.node_index} < 11'(NODES);
	assign addr     = AW'(cmd.node_index);
	assign missing  = !in_range || !pose_valid_q[addr];
	assign pose     = pose_t'(ram_rdata);
	assign res_free = !res_valid_q || !res_stall;

	assign ang_fix = (cmd.angle >= 16'd16384 && cmd.angle < 16'd49152) ?
		cmd.angle + 16'd32768 : cmd.angle;
	assign xs = cx_q >>> cnt_q;
	assign ys = cy_q >>> cnt_q;

	always_comb begin
		pose_wr       = '0;
		pose_wr.tx    = in_q.point_x;
		pose_wr.ty    = in_q.point_y;
		pose_wr.sx    = in_q.scale_x;
		pose_wr.sy    = in_q.scale_y;
		pose_wr.px    = in_q.pivot_x;
		pose_wr.py    = in_q.pivot_y;
		pose_wr.cos_v = flip_q ? 32'(-cx_q) : cx_q[31:0];
		pose_wr.sin_v = flip_q ? 32'(-cy_q) : cy_q[31:0];
	end

	always_comb begin
		if (vstat_q == STAT_NEG)
			stat_calc = STAT_NEG;
		else if ($signed(weight_sum_q) <= 32'sd0)
			stat_calc = STAT_NONPOS;
		else
			stat_calc = vstat_q;
	end

	// Multiplier operands per step; the product of step k is used in step k+1.
	always_comb begin
		case (cnt_q)
			5'd0: begin
				mul_a = 33'(in_q.point_x) - 33'(pose.px);
				mul_b = 33'(pose.sx);
			end
			5'd1: begin
				mul_a = 33'(in_q.point_y) - 33'(pose.py);
				mul_b = 33'(pose.sy);
			end
			5'd2: begin
				mul_a = 33'(lx_q);
				mul_b = 33'(pose.cos_v);
			end
			5'd3: begin
				mul_a = 33'(ly_q);
				mul_b = 33'(pose.sin_v);
			end
			5'd4: begin
				mul_a = 33'(lx_q);
				mul_b = 33'(pose.sin_v);
			end
			5'd5: begin
				mul_a = 33'(ly_q);
				mul_b = 33'(pose.cos_v);
			end
			5'd6: begin
				mul_a = 33'(lx_q);
				mul_b = 33'(in_q.weight);
			end
			5'd7: begin
				mul_a = 33'(ly_q);
				mul_b = 33'(in_q.weight);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign product = mul_a * mul_b;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.command)
						CMD_LOAD: state_d = in_range ? ST_CORDIC : ST_IDLE;
						CMD_INFL: begin
							if (!missing)
								state_d = ST_MUL;
							else if (cmd.last_influence)
								state_d = ST_CHECK;
							else
								state_d = ST_IDLE;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_CORDIC:    if (cnt_q == 5'(C_STEPS - 1)) state_d = ST_LOAD_WR;
			ST_LOAD_WR:   state_d = ST_IDLE;
			ST_MUL: begin
				if (cnt_q == 5'(MUL_LAST))
					state_d = in_q.last_influence ? ST_CHECK : ST_IDLE;
			end
			ST_CHECK:     state_d = (stat_calc == STAT_OK) ? ST_DIVX_GO : ST_FINISH;
			ST_DIVX_GO:   state_d = ST_DIVX_WAIT;
			ST_DIVX_WAIT: if (div_done) state_d = ST_DIVY_GO;
			ST_DIVY_GO:   state_d = ST_DIVY_WAIT;
			ST_DIVY_WAIT: if (div_done) state_d = ST_FINISH;
			ST_FINISH:    if (res_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		cmd_stall      = state_q != ST_IDLE;
		ram_we         = state_q == ST_LOAD_WR;
		ram_re         = accept && cmd.command == CMD_INFL && !missing;
		div_ctrl.start = state_q == ST_DIVX_GO || state_q == ST_DIVY_GO;
		div_ctrl.sel_y = state_q == ST_DIVY_GO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			pose_valid_q <= '0;
			sum_x_q      <= '0;
			sum_y_q      <= '0;
			weight_sum_q <= '0;
			vstat_q      <= STAT_OK;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FINISH && res_free)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && cmd.command == CMD_CLEAR)
						pose_valid_q <= '0;
					if (accept && cmd.command == CMD_INFL) begin
						weight_sum_q <= weight_sum_q + 32'(cmd.weight);
						if (cmd.weight < 16'sd0)
							vstat_q <= STAT_NEG;
						else if (missing && vstat_q == STAT_OK)
							vstat_q <= STAT_MISSING;
					end
				end
				ST_CORDIC: cnt_q <= cnt_q + 5'd1;
				ST_LOAD_WR: pose_valid_q[AW'(in_q.node_index)] <= 1'b1;
				ST_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd7)
						sum_x_q <= sum_x_q + prod_q[63:0];
					if (cnt_q == 5'd8)
						sum_y_q <= sum_y_q + prod_q[63:0];
				end
				ST_FINISH: begin
					if (res_free) begin
						sum_x_q      <= '0;
						sum_y_q      <= '0;
						weight_sum_q <= '0;
						vstat_q      <= STAT_OK;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept)
			in_q <= cmd;
		case (state_q)
			ST_IDLE: begin
				flip_q <= cmd.angle >= 16'd16384 && cmd.angle < 16'd49152;
				cx_q   <= CORDIC_START;
				cy_q   <= '0;
				cz_q   <= {{2{ang_fix[15]}}, ang_fix, 16'd0};
			end
			ST_CORDIC: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - 34'(atan_turn(cnt_q));
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + 34'(atan_turn(cnt_q));
				end
			end
			ST_MUL: begin
				prod_q <= product;
				case (cnt_q)
					5'd1: lx_q <= sat32(68'(prod_q >>> 16) + 68'(pose.px));
					5'd2: ly_q <= sat32(68'(prod_q >>> 16) + 68'(pose.py));
					5'd3: t_q  <= prod_q;
					5'd4: lx_q <= sat32(((68'(t_q) - 68'(prod_q)) >>> 30) + 68'(pose.tx));
					5'd5: t_q  <= prod_q;
					5'd6: ly_q <= sat32(((68'(t_q) + 68'(prod_q)) >>> 30) + 68'(pose.ty));
					default: ;
				endcase
			end
			ST_CHECK: stat_q <= stat_calc;
			ST_DIVX_WAIT: if (div_done) ox_q <= div_q;
			ST_FINISH: begin
				if (res_free) begin
					res_q.status <= stat_q;
					res_q.out_x  <= (stat_q == STAT_OK) ? ox_q : 32'sd0;
					res_q.out_y  <= (stat_q == STAT_OK) ? div_q : 32'sd0;
				end
			end
			default: ;
		endcase
	end

	sknv_ram #(
		.WIDTH($bits(pose_t)),
		.DEPTH(NODES)
	) u_pose_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_q.node_index)),
		.wdata (pose_wr),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	sknv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.sum_x    (sum_x_q),
		.sum_y    (sum_y_q),
		.divisor  (weight_sum_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVX_WAIT || state_q == ST_DIVY_WAIT))
		else $error("divider finished outside a wait state");

	a_res_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

	a_err_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != STAT_OK) |-> (res_q.out_x == 0 && res_q.out_y == 0))
		else $error("error result carries a position");
`endif
endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for blend_skin_vertex_2d: pose loads, clears and vertex influences
// against an in-bench predictor of the CORDIC, skinning and division math.
// Depends on sknv_pkg and the blend_skin_vertex_2d RTL.
`timescale 1ns / 1ps

module tb_top;
	import sknv_pkg::*;

	localparam int SLOTS = 64;
	localparam int ROT_STEPS = 16;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 300;
	localparam logic [1:0] CMD_NOP = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_item_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_item_t res;

	blend_skin_vertex_2d dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always #5 clk = ~clk;

	// pose store of the predictor
	longint pose_tx[SLOTS], pose_ty[SLOTS], pose_sx[SLOTS], pose_sy[SLOTS];
	longint pose_px[SLOTS], pose_py[SLOTS], pose_cos[SLOTS], pose_sin[SLOTS];
	bit pose_live[SLOTS];
	longint acc_x, acc_y;
	int weight_total;
	logic [1:0] vtx_status;
	res_item_t expected_pos[$];

	longint turn_step[ROT_STEPS] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861};

	int n_items = 0, n_checked = 0, n_errors = 0, idle_cycles = 0, burst_left = 0;
	int hold_left = 0, stall_mode = 0, stall_count = 0;
	int n_stat[4] = '{0, 0, 0, 0};

	function automatic longint clamp_word(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint word_of(input longint v);
		logic [31:0] w;
		w = v[31:0];
		return longint'($signed(w));
	endfunction

	task automatic pose_trig(input logic [15:0] ang, output longint c, output longint s);
		logic [15:0] a;
		bit flip;
		longint x, y, z, xs, ys;
		a = ang;
		flip = (a >= 16'd16384 && a < 16'd49152);
		if (flip) a = a + 16'd32768;
		z = longint'($signed(a)) * 65536;
		x = 652032874;
		y = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= turn_step[i];
			end else begin
				x += ys; y -= xs; z += turn_step[i];
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = word_of(x);
		s = word_of(y);
	endtask

	task automatic skin_predict(input cmd_item_t it);
		longint w, lx, ly, mx, my, ws;
		res_item_t r;
		int n;
		n = it.node_index;
		case (it.command)
			CMD_CLEAR: for (int k = 0; k < SLOTS; k++) pose_live[k] = 1'b0;
			CMD_LOAD: begin
				pose_tx[n] = it.point_x; pose_ty[n] = it.point_y;
				pose_sx[n] = it.scale_x; pose_sy[n] = it.scale_y;
				pose_px[n] = it.pivot_x; pose_py[n] = it.pivot_y;
				pose_trig(it.angle, pose_cos[n], pose_sin[n]);
				pose_live[n] = 1'b1;
			end
			CMD_INFL: begin
				w = it.weight;
				weight_total += int'(w);
				if (w < 0) vtx_status = STAT_NEG;
				if (!pose_live[n]) begin
					if (vtx_status == STAT_OK) vtx_status = STAT_MISSING;
				end else begin
					lx = clamp_word((((longint'(it.point_x) - pose_px[n]) * pose_sx[n]) >>> 16)
						+ pose_px[n]);
					ly = clamp_word((((longint'(it.point_y) - pose_py[n]) * pose_sy[n]) >>> 16)
						+ pose_py[n]);
					mx = clamp_word(((lx * pose_cos[n] - ly * pose_sin[n]) >>> 30) + pose_tx[n]);
					my = clamp_word(((lx * pose_sin[n] + ly * pose_cos[n]) >>> 30) + pose_ty[n]);
					acc_x += mx * w;
					acc_y += my * w;
				end
				if (it.last_influence) begin
					ws = weight_total;
					r = '0;
					if (vtx_status == STAT_NEG) r.status = STAT_NEG;
					else if (ws <= 0) r.status = STAT_NONPOS;
					else r.status = vtx_status;
					if (r.status == STAT_OK) begin
						r.out_x = clamp_word(acc_x / ws);
						r.out_y = clamp_word(acc_y / ws);
					end
					expected_pos = {expected_pos, r};
					acc_x = 0; acc_y = 0; weight_total = 0; vtx_status = STAT_OK;
				end
			end
			default: ;
		endcase
	endtask

	// Offer one item, hold it until accepted, then maybe idle between bursts.
	task automatic send_item(input cmd_item_t it);
		int gap;
		cmd <= it;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		skin_predict(it);
		n_items++;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	function automatic cmd_item_t noise_item();
		logic [255:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return raw[$bits(cmd_item_t)-1:0];
	endfunction

	function automatic cmd_item_t load_item(input int n, input logic [31:0] tx, ty, sx, sy,
		px, py, input logic [15:0] ang);
		cmd_item_t it;
		it = noise_item();
		it.command = CMD_LOAD; it.node_index = 6'(n);
		it.point_x = tx; it.point_y = ty; it.scale_x = sx; it.scale_y = sy;
		it.pivot_x = px; it.pivot_y = py; it.angle = ang;
		return it;
	endfunction

	function automatic cmd_item_t infl_item(input int n, input logic [31:0] rx, ry,
		input logic [15:0] w, input bit last);
		cmd_item_t it;
		it = noise_item();
		it.command = CMD_INFL; it.node_index = 6'(n);
		it.point_x = rx; it.point_y = ry; it.weight = w; it.last_influence = last;
		return it;
	endfunction

	function automatic cmd_item_t cmd_only(input logic [1:0] c);
		cmd_item_t it;
		it = noise_item();
		it.command = c;
		return it;
	endfunction

	function automatic logic [31:0] rand_q16();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return $urandom_range(0, 32'h3ffff) - 32'h20000;
	endfunction

	function automatic cmd_item_t rand_load();
		logic [31:0] sx, sy;
		sx = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 32'h30000) - 32'h10000;
		sy = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 32'h30000) - 32'h10000;
		return load_item($urandom_range(0, SLOTS - 1), rand_q16(), rand_q16(), sx, sy,
			rand_q16(), rand_q16(), 16'($urandom));
	endfunction

	task automatic send_vertex();
		int cnt, n;
		logic [15:0] w;
		cnt = $urandom_range(1, 4);
		for (int i = 0; i < cnt; i++) begin
			n = $urandom_range(0, SLOTS - 1);
			if ($urandom_range(0, 99) < 85)
				for (int t = 0; t < 8 && !pose_live[n]; t++) n = $urandom_range(0, SLOTS - 1);
			w = $urandom_range(0, 19) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8192));
			send_item(infl_item(n, rand_q16(), rand_q16(), w, i == cnt - 1));
		end
	endtask

	task automatic test_directed();
		send_item(cmd_only(CMD_CLEAR));
		send_item(load_item(0, 0, 0, 32'h10000, 32'h10000, 0, 0, 16'd0));
		send_item(load_item(1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 16'd16384));
		send_item(load_item(63, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 16'd32768));
		send_item(load_item(5, 32'h10000, 32'hffff0000, 32'h8000, 32'h20000, 32'h1000,
			32'h2000, 16'd49152));
		send_item(load_item(6, 0, 32'h50000, 32'h10000, 32'hffff0000, 0, 0, 16'd65535));
		send_item(infl_item(0, 32'h640000, 32'hff9c0000, 16'd4096, 1'b1));
		send_item(infl_item(1, 32'h7fffffff, 32'h80000000, 16'h7fff, 1'b0));
		send_item(infl_item(63, 32'h80000000, 32'h7fffffff, 16'd2048, 1'b1));
		send_item(infl_item(6, 32'h12345, 32'h54321, 16'd4096, 1'b0));
		send_item(infl_item(5, 32'h30000, 32'h40000, 16'h8000, 1'b1));
		send_item(infl_item(40, 32'h10000, 32'h10000, 16'd4096, 1'b1));
		send_item(infl_item(0, 32'h10000, 32'h10000, 16'd0, 1'b1));
		send_item(infl_item(5, 32'h10000, 0, 16'd4096, 1'b0));
		send_item(infl_item(6, 0, 32'h10000, 16'hf000, 1'b1));
		send_item(cmd_only(CMD_NOP));
		send_item(infl_item(0, 32'h20000, 32'h20000, 16'd4096, 1'b0));
		send_item(cmd_only(CMD_CLEAR));
		send_item(infl_item(0, 32'h20000, 32'h20000, 16'd4096, 1'b1));
	endtask

	task automatic test_random();
		int r;
		for (int i = 0; i < 16; i++) send_item(rand_load());
		while (n_items < 600) begin
			r = $urandom_range(0, 99);
			if (r < 10) send_item(rand_load());
			else if (r < 12) send_item(cmd_only(CMD_CLEAR));
			else if (r < 15) send_item(cmd_only(CMD_NOP));
			else send_vertex();
		end
	endtask

	// Hold the output off for a long stretch while vertices keep coming.
	task automatic test_backpressure();
		for (int i = 0; i < 8; i++) send_item(rand_load());
		hold_left = 500;
		for (int i = 0; i < 10; i++) send_vertex();
	endtask

	// Receiver stall pattern: free, light or heavy stalling, chosen at random.
	always @(negedge clk) begin
		stall_count++;
		if (stall_count % 64 == 0) stall_mode = $urandom_range(0, 2);
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (stall_mode == 0) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= ($urandom_range(0, 99) < (stall_mode == 1 ? 30 : 75));
		end
	end

	always @(posedge clk) begin
		res_item_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_pos.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("unexpected result x=%0d y=%0d status=%0d",
					res.out_x, res.out_y, res.status);
			end else begin
				e = expected_pos.pop_front();
				n_checked++;
				n_stat[e.status]++;
				if (res.out_x !== e.out_x || res.out_y !== e.out_y || res.status !== e.status)
					begin
					n_errors++;
					if (n_errors <= 10)
						$display("result %0d: expected x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
							n_checked, e.out_x, e.out_y, e.status, res.out_x, res.out_y,
							res.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < SLOTS; k++) pose_live[k] = 1'b0;
		acc_x = 0; acc_y = 0; weight_total = 0; vtx_status = STAT_OK;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random();
		cmd_valid <= 1'b0;
		while (expected_pos.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d items, checked %0d vertices", n_items, n_checked);
		$display("status mix: ok %0d, missing pose %0d, negative weight %0d, bad sum %0d",
			n_stat[0], n_stat[1], n_stat[2], n_stat[3]);
		if (n_errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
